// File: rtl/ath_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ath_pkg
// Shared types, codes and helpers of the allocation tracking hash table.
// ----------------------------------------------------------------------------
package ath_pkg;

  // The slot count must be a power of two, so that the home slot is a mask.
  localparam int TABLE_SLOTS = 128;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int HASH_STEPS  = 4;
  localparam int STEP_W      = $clog2(HASH_STEPS);
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 1;

  localparam logic [31:0] HASH_SEED = 32'd5381;

  localparam logic [CFG_IDX_W-1:0] CFG_TRACKING_ENABLE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_RELEASE_CHECK = 1'd1;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_MOVE    = 2'd2;

  localparam logic [2:0] OP_OFF     = 3'd0;
  localparam logic [2:0] OP_NOP     = 3'd1;
  localparam logic [2:0] OP_ALLOC   = 3'd2;
  localparam logic [2:0] OP_RELEASE = 3'd3;
  localparam logic [2:0] OP_MOVE    = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DOUBLE   = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_DISABLED = 3'd4;

  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_VALID   = 2'd1;
  localparam logic [1:0] SLOT_DELETED = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] address;
    logic [63:0] new_address;
  } ath_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] slot_index;
    logic [7:0] entry_total;
  } ath_out_t;

  typedef struct packed {
    logic tracking_enable;
    logic double_release_check;
  } ath_cfg_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [63:0]       address;
    logic [63:0]       new_address;
    logic [SLOT_W-1:0] home_a;
    logic [SLOT_W-1:0] home_n;
  } ath_job_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        released;
    logic [63:0] key;
  } ath_entry_t;

  localparam int ENTRY_W = $bits(ath_entry_t);

  function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
    hash_step = (h << 5) + h + {24'd0, b};
  endfunction

endpackage
`default_nettype wire

// File: rtl/ath_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ath_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ath_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/ath_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ath_front
// Accepts a command, classifies it and hashes both addresses to home slots.
// ----------------------------------------------------------------------------
module ath_front
  import ath_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire ath_in_t  item,
  input  wire ath_cfg_t cfg,
  input  wire logic     q_full,
  output logic          busy,
  output logic          push,
  output ath_job_t      push_job
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HASH = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]        state;
  logic [STEP_W-1:0] step;
  logic [2:0]        op;
  logic [63:0]       addr;
  logic [63:0]       naddr;
  logic [31:0]       ha;
  logic [31:0]       hn;
  logic [15:0]       byte_a;
  logic [15:0]       byte_n;

  assign busy   = (state != F_IDLE);
  assign push   = (state == F_PUSH) && !q_full;
  assign byte_a = addr[16*step +: 16];
  assign byte_n = naddr[16*step +: 16];

  always_comb begin
    push_job.op          = op;
    push_job.address     = addr;
    push_job.new_address = naddr;
    push_job.home_a      = ha[SLOT_W-1:0];
    push_job.home_n      = hn[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            addr  <= item.address;
            naddr <= item.new_address;
            ha    <= HASH_SEED;
            hn    <= HASH_SEED;
            step  <= '0;
            if (!cfg.tracking_enable) begin
              op <= OP_OFF;
            end else begin
              case (item.command)
                CMD_ALLOC:   op <= OP_ALLOC;
                CMD_RELEASE: op <= OP_RELEASE;
                CMD_MOVE:    op <= OP_MOVE;
                default:     op <= OP_NOP;
              endcase
            end
            state <= F_HASH;
          end
        end
        F_HASH: begin
          ha   <= hash_step(hash_step(ha, byte_a[7:0]), byte_a[15:8]);
          hn   <= hash_step(hash_step(hn, byte_n[7:0]), byte_n[15:8]);
          step <= step + 1'b1;
          if (step == STEP_W'(HASH_STEPS - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/ath_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ath_queue
// Short queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module ath_queue
  import ath_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire ath_job_t din,
  input  wire logic     pop,
  output ath_job_t      dout,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  ath_job_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   fill;

  assign full  = (fill == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign dout  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/ath_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ath_back
// Walks probe chains in the slot memory and carries out each command.
// ----------------------------------------------------------------------------
module ath_back
  import ath_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire ath_cfg_t cfg,
  input  wire logic     q_empty,
  input  wire ath_job_t q_job,
  output logic          pop,
  output logic          done,
  output ath_out_t      result
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_READ = 3'd1;
  localparam logic [2:0] B_EVAL = 3'd2;
  localparam logic [2:0] B_WR1  = 3'd3;
  localparam logic [2:0] B_WR2  = 3'd4;

  logic [2:0]             state;
  ath_job_t               job;
  logic                   phase_b;
  logic [SLOT_W-1:0]      s;
  logic [SLOT_W-1:0]      n;
  logic [63:0]            target;
  logic [SLOT_W-1:0]      old_slot;
  logic                   mark;
  logic                   free_ok;
  logic [SLOT_W-1:0]      free_slot;
  logic                   wr1_en;
  logic [SLOT_W-1:0]      wr1_addr;
  ath_entry_t             wr1_data;
  logic                   wr2_en;
  logic [SLOT_W-1:0]      wr2_addr;
  logic [2:0]             res_status;
  logic [SLOT_W-1:0]      res_slot;
  logic [CNT_W-1:0]       count;
  logic [TABLE_SLOTS-1:0] written;
  logic                   flag_q;

  logic                   we;
  logic [SLOT_W-1:0]      waddr;
  ath_entry_t             wdata;
  logic [ENTRY_W-1:0]     rdata;
  ath_entry_t             rd;
  logic [1:0]             st;
  logic                   free_ok_now;
  logic [SLOT_W-1:0]      free_now;
  logic                   hit;
  logic                   stop_miss;
  logic                   to_new;

  ath_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (s),
    .rdata (rdata)
  );

  assign pop = (state == B_IDLE) && !q_empty;
  assign rd  = rdata;

  always_comb begin
    we    = 1'b0;
    waddr = wr1_addr;
    wdata = wr1_data;
    if (state == B_WR1) begin
      we = wr1_en;
    end else if (state == B_WR2) begin
      we    = wr2_en;
      waddr = wr2_addr;
      wdata = '{status: SLOT_DELETED, released: 1'b0, key: 64'd0};
    end
  end

  always_comb begin
    st = flag_q ? rd.status : SLOT_EMPTY;
    if (phase_b && (s == old_slot)) begin
      st = SLOT_DELETED;
    end
    free_ok_now = free_ok || (st != SLOT_VALID);
    free_now    = free_ok ? free_slot : s;
    hit         = (st == SLOT_VALID) && (rd.key == target);
    stop_miss   = !hit && ((st == SLOT_EMPTY) || (n == SLOT_W'(TABLE_SLOTS - 1)));
    to_new      = !phase_b && (job.op == OP_MOVE) && hit;
  end

  always_ff @(posedge clk) begin
    flag_q <= written[s];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      count   <= '0;
      done    <= 1'b0;
      written <= '0;
    end else begin
      done <= (state == B_WR2);
      if (we) begin
        written[waddr] <= 1'b1;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            job        <= q_job;
            phase_b    <= 1'b0;
            s          <= q_job.home_a;
            n          <= '0;
            target     <= q_job.address;
            free_ok    <= 1'b0;
            wr1_en     <= 1'b0;
            wr2_en     <= 1'b0;
            res_slot   <= '0;
            if (q_job.op == OP_OFF) begin
              res_status <= ST_DISABLED;
              state      <= B_WR2;
            end else if (q_job.op == OP_NOP) begin
              res_status <= ST_OK;
              state      <= B_WR2;
            end else begin
              res_status <= ST_OK;
              state      <= B_READ;
            end
          end
        end
        B_READ: begin
          state <= B_EVAL;
        end
        B_EVAL: begin
          free_ok   <= free_ok_now && !to_new;
          free_slot <= free_now;
          if (hit || stop_miss) begin
            state <= to_new ? B_READ : B_WR1;
            if (!phase_b) begin
              case (job.op)
                OP_ALLOC: begin
                  wr1_data <= '{status: SLOT_VALID, released: 1'b0, key: target};
                  if (hit) begin
                    wr1_en   <= 1'b1;
                    wr1_addr <= s;
                    res_slot <= s;
                  end else if (free_ok_now) begin
                    wr1_en   <= 1'b1;
                    wr1_addr <= free_now;
                    res_slot <= free_now;
                    count    <= count + 1'b1;
                  end else begin
                    res_status <= ST_FULL;
                  end
                end
                OP_RELEASE: begin
                  wr1_data <= '{status: SLOT_VALID, released: 1'b1, key: target};
                  if (!hit) begin
                    res_status <= ST_NOTFOUND;
                  end else if (rd.released && cfg.double_release_check) begin
                    res_status <= ST_DOUBLE;
                  end else begin
                    wr1_en   <= 1'b1;
                    wr1_addr <= s;
                    res_slot <= s;
                  end
                end
                OP_MOVE: begin
                  if (hit) begin
                    old_slot <= s;
                    mark     <= rd.released;
                    phase_b  <= 1'b1;
                    s        <= job.home_n;
                    n        <= '0;
                    target   <= job.new_address;
                  end else begin
                    res_status <= ST_NOTFOUND;
                  end
                end
                default: begin
                  res_status <= ST_OK;
                end
              endcase
            end else begin
              wr1_data <= '{status: SLOT_VALID, released: mark, key: target};
              wr2_addr <= old_slot;
              if (hit) begin
                wr1_en   <= 1'b1;
                wr1_addr <= s;
                wr2_en   <= 1'b1;
                res_slot <= s;
                count    <= count - 1'b1;
              end else if (free_ok_now) begin
                wr1_en   <= 1'b1;
                wr1_addr <= free_now;
                wr2_en   <= (free_now != old_slot);
                res_slot <= free_now;
              end else begin
                res_status <= ST_FULL;
              end
            end
          end else begin
            s     <= s + 1'b1;
            n     <= n + 1'b1;
            state <= B_READ;
          end
        end
        B_WR1: begin
          state <= B_WR2;
        end
        B_WR2: begin
          result.status     <= res_status;
          result.slot_index <= (res_status == ST_OK) ? 7'(res_slot) : 7'd0;
          result.entry_total <= 8'(count);
          state             <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/allocation_tracking_hash_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// allocation_tracking_hash_table
// Open-addressing table of allocated block addresses with linear probing.
//
//   Channel   Signals                          Handshake
//   command   start, busy, item                accepted when start && !busy
//   result    done, result                     one-cycle strobe, no stall
//   config    cfg_we, cfg_index, cfg_data      written when cfg_we is high
//
// The front hashes both addresses over its hash steps and queues the command,
// waiting while the queue is full, after which it can take the next command
// while the back is still working. The back takes a command, reads and then
// compares each probed slot (B_READ, B_EVAL), walks both chains for a move,
// and ends in the write states B_WR1 and B_WR2; a command with tracking off
// or an unused command code goes straight to B_WR2.
// Reset empties the table at once through per-slot written flags.
// ----------------------------------------------------------------------------
module allocation_tracking_hash_table
  import ath_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire ath_in_t              item,
  output logic                      done,
  output ath_out_t                  result,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic                 cfg_data
);

  ath_cfg_t cfg;
  logic     push;
  ath_job_t push_job;
  logic     pop;
  ath_job_t q_job;
  logic     q_full;
  logic     q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRACKING_ENABLE:      cfg.tracking_enable      <= cfg_data;
        CFG_DOUBLE_RELEASE_CHECK: cfg.double_release_check <= cfg_data;
        default:                  cfg <= cfg;
      endcase
    end
  end

  ath_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .cfg      (cfg),
    .q_full   (q_full),
    .busy     (busy),
    .push     (push),
    .push_job (push_job)
  );

  ath_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_job),
    .pop   (pop),
    .dout  (q_job),
    .full  (q_full),
    .empty (q_empty)
  );

  ath_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_job   (q_job),
    .pop     (pop),
    .done    (done),
    .result  (result)
  );

endmodule
`default_nettype wire

// File: rtl/ath_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ath_checker
// Port-level checks of the allocation tracking hash table.
// ----------------------------------------------------------------------------
module ath_checker
  import ath_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     done,
  input wire ath_out_t result
);

  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("Result strobe straight after reset.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status <= ST_DISABLED))
    else $error("Unknown status code.");

  a_slot_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != ST_OK)) |-> (result.slot_index == 7'd0))
    else $error("Slot index set on a failed transaction.");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.entry_total <= 8'(TABLE_SLOTS)))
    else $error("Entry total beyond the table size.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Not busy after an accepted transaction.");

endmodule

bind allocation_tracking_hash_table ath_checker u_ath_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire
